// ----- design/kbsc_pkg.sv -----
package kbsc_pkg;

  localparam int POOL_DEPTH    = 128;
  localparam int AW            = $clog2(POOL_DEPTH);
  localparam int WARMUP_ROUNDS = 2048;
  localparam int CNT_W         = $clog2(WARMUP_ROUNDS + 1);
  localparam int PADDR_W       = 3;

  localparam logic [AW-1:0] PTR_SLOT   = AW'(POOL_DEPTH - 1);
  localparam logic [AW-1:0] LAST_ENTRY = AW'(POOL_DEPTH - 2);
  localparam logic [7:0]    PTR_MASK   = 8'(POOL_DEPTH - 1);

  localparam logic [PADDR_W-3:0] REG_SEED_WORD = '0;

  typedef enum logic [1:0] {
    FUNC_SEED = 2'd0,
    FUNC_KEY  = 2'd1,
    FUNC_WARM = 2'd2,
    FUNC_DATA = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_KEY_RD,
    ST_KEY_WR,
    ST_DRAW_A,
    ST_DRAW_B,
    ST_DRAW_C
  } state_t;

  typedef struct packed {
    logic          start;
    func_t         func;
    logic [AW-1:0] key_index;
    logic [7:0]    data;
  } cmd_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } result_t;

endpackage

// ----- design/kbsc_ram.sv -----
module kbsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/kbsc_engine.sv -----
module kbsc_engine import kbsc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  input  logic [31:0] seed_word,
  output logic        busy,
  output result_t     result
);

  state_t state_r, state_nxt;
  logic [7:0]       ptr_r, ptr_nxt;
  logic [AW-1:0]    addr_r, addr_nxt;
  logic [7:0]       byte_r, byte_nxt;
  logic [AW-1:0]    slot_r, slot_nxt;
  logic [7:0]       pinc_r, pinc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             data_r, data_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  logic [7:0]    add_a, add_b, add_sum;
  logic [7:0]    pool_val;
  logic [AW-1:0] slot_c;
  logic [7:0]    fill_byte;

  kbsc_ram #(.WIDTH(8), .DEPTH(POOL_DEPTH)) u_pool (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The pointer lives in ptr_r, so a read of its slot is served from the register.
  assign pool_val  = (ptr_r[AW-1:0] == PTR_SLOT) ? ptr_r : ram_rdata;
  assign fill_byte = seed_word[{addr_r[1:0], 3'b000} +: 8];
  assign add_sum   = add_a + add_b;
  assign slot_c    = (add_sum[AW-1:0] == PTR_SLOT) ? '0 : add_sum[AW-1:0];
  assign busy      = (state_r != ST_IDLE);

  always_comb begin
    add_a = ptr_r;
    add_b = 8'd1;
    unique case (state_r)
      ST_DRAW_B: begin
        add_b = pool_val;
      end
      ST_DRAW_C: begin
        add_a = ram_rdata;
        add_b = pinc_r;
      end
      ST_CLEAR, ST_IDLE, ST_FILL, ST_KEY_RD, ST_KEY_WR, ST_DRAW_A: begin
        add_a = ptr_r;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR, ST_FILL: begin
        if (addr_r == LAST_ENTRY) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd.start) begin
          unique case (cmd.func)
            FUNC_SEED: state_nxt = ST_FILL;
            FUNC_KEY:  state_nxt = (cmd.key_index == PTR_SLOT) ? ST_IDLE : ST_KEY_RD;
            FUNC_WARM: state_nxt = (WARMUP_ROUNDS == 0) ? ST_IDLE : ST_DRAW_A;
            FUNC_DATA: state_nxt = ST_DRAW_A;
          endcase
        end
      end
      ST_KEY_RD: state_nxt = ST_KEY_WR;
      ST_KEY_WR: state_nxt = ST_IDLE;
      ST_DRAW_A: state_nxt = ST_DRAW_B;
      ST_DRAW_B: state_nxt = ST_DRAW_C;
      ST_DRAW_C: begin
        state_nxt = (data_r || cnt_r == CNT_W'(1)) ? ST_IDLE : ST_DRAW_A;
      end
    endcase
  end

  always_comb begin
    ptr_nxt   = ptr_r;
    addr_nxt  = addr_r;
    byte_nxt  = byte_r;
    slot_nxt  = slot_r;
    pinc_nxt  = pinc_r;
    cnt_nxt   = cnt_r;
    data_nxt  = data_r;
    ram_we    = 1'b0;
    ram_waddr = addr_r;
    ram_wdata = '0;
    ram_raddr = addr_r;
    result    = '0;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we   = 1'b1;
        addr_nxt = addr_r + 1'b1;
      end
      ST_IDLE: begin
        if (cmd.start) begin
          byte_nxt = cmd.data;
          data_nxt = (cmd.func == FUNC_DATA);
          cnt_nxt  = CNT_W'(WARMUP_ROUNDS);
          addr_nxt = '0;
          unique case (cmd.func)
            FUNC_SEED: ptr_nxt = seed_word[31:24];
            FUNC_KEY: begin
              if (cmd.key_index == PTR_SLOT) begin
                ptr_nxt = ptr_r ^ cmd.data;
              end else begin
                addr_nxt = cmd.key_index;
              end
            end
            FUNC_WARM: ptr_nxt = ptr_r & PTR_MASK;
            FUNC_DATA: ptr_nxt = ptr_r;
          endcase
        end
      end
      ST_FILL: begin
        ram_we    = 1'b1;
        ram_wdata = fill_byte;
        addr_nxt  = addr_r + 1'b1;
      end
      ST_KEY_RD: begin
        ram_raddr = addr_r;
      end
      ST_KEY_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata ^ byte_r;
      end
      ST_DRAW_A: begin
        ram_raddr = ptr_r[AW-1:0];
        pinc_nxt  = add_sum;
      end
      ST_DRAW_B: begin
        slot_nxt  = slot_c;
        ram_raddr = slot_c;
      end
      ST_DRAW_C: begin
        ram_we       = 1'b1;
        ram_waddr    = slot_r;
        ram_wdata    = add_sum;
        ptr_nxt      = {{(8-AW){1'b0}}, slot_r};
        cnt_nxt      = cnt_r - 1'b1;
        result.valid = data_r;
        result.data  = byte_r ^ add_sum;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      ptr_r   <= '0;
      addr_r  <= '0;
      cnt_r   <= '0;
      data_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
      addr_r  <= addr_nxt;
      cnt_r   <= cnt_nxt;
      data_r  <= data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    slot_r <= slot_nxt;
    pinc_r <= pinc_nxt;
  end

endmodule

// ----- design/keyed_byte_stream_cipher_unit.sv -----
// A data beat keeps it busy through DRAW_A, DRAW_B and DRAW_C; its result is shown in the
// cycle after, a draw using the single pool memory and the shared 8-bit adder. A key beat
// keeps it busy through KEY_RD and KEY_WR (none when it hits the pointer slot), a seed
// fill writes pool entries 0 to 126 (one pool entry per cycle) and a warm-up runs 2048
// draws, one item at a time. Synchronous active-low reset; afterwards a clearing pass
// zeroes entries 0 to 126 while input beats stall; register writes are still taken.
module keyed_byte_stream_cipher_unit import kbsc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_func,
  input  logic [6:0]         in_key_index,
  input  logic [7:0]         in_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte
);

  logic [31:0] seed_r;
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        busy;
  cmd_t        cmd;
  result_t     result;
  logic        seed_sel;

  assign seed_sel = (paddr[PADDR_W-1:2] == REG_SEED_WORD);
  assign pready   = 1'b1;
  assign prdata   = seed_sel ? seed_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (psel && penable && pwrite && seed_sel) begin
      seed_r <= pwdata;
    end
  end

  // A data beat waits until the output register is free.
  assign in_stall = busy || (out_valid_r && (func_t'(in_func) == FUNC_DATA));

  assign cmd.start     = in_valid && !in_stall;
  assign cmd.func      = func_t'(in_func);
  assign cmd.key_index = in_key_index;
  assign cmd.data      = in_byte;

  kbsc_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .seed_word (seed_r),
    .busy      (busy),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (result.valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result.valid) begin
      out_byte_r <= result.data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;

endmodule

// ----- design/kbsc_checker.sv -----
module kbsc_checker import kbsc_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] in_func,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte
);

  logic data_beat;
  assign data_beat = in_valid && !in_stall && (func_t'(in_func) == FUNC_DATA);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte))
    else $error("stalled output beat changed");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_data_result: assert property (@(posedge clk) disable iff (!rst_n)
    data_beat |-> ##4 out_valid)
    else $error("data beat gave no result on time");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(data_beat, 4))
    else $error("result without a data beat");

endmodule

bind keyed_byte_stream_cipher_unit kbsc_checker u_kbsc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_func   (in_func),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_byte  (out_byte)
);
